// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker file sat_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAT_ASSERT_IMP(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SAT_ASSERT_NXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ===== hw/rtl/sat_pkg.sv =====
package sat_pkg;

  // Default sizing of the table
  localparam int SAT_CAPACITY  = 256;
  localparam int SAT_KEY_WIDTH = 32;

  // Fixed port field widths
  localparam int REQ_W   = 2;
  localparam int KEY_W   = 32;
  localparam int POS_W   = 8;
  localparam int WHERE_W = 8;
  localparam int FILL_W  = 9;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_RM_KEY = 2'd2,
    REQ_RM_POS = 2'd3
  } sat_req_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DECIDE,
    ST_SHIFT,
    ST_FIN,
    ST_DONE
  } sat_state_t;

endpackage

// ===== hw/rtl/sat_ram.sv =====
module sat_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/sorted_array_table.sv =====
// Sorted key table: binary search over a one-read/one-write memory, then shift for add
// and remove by key; remove at position shifts without a search. One entry moved per cycle.
// One request at a time: no new request is taken until the last result is in the output register.
// Reset clears the entry count and handshakes only; the key memory is not cleared.
module sorted_array_table #(
  parameter int CAPACITY  = sat_pkg::SAT_CAPACITY,
  parameter int KEY_WIDTH = sat_pkg::SAT_KEY_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sat_pkg::REQ_W-1:0]    in_req_type,
  input  logic [sat_pkg::KEY_W-1:0]    in_key,
  input  logic [sat_pkg::POS_W-1:0]    in_position,
  input  logic                         in_allow_dup,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_ok,
  output logic [sat_pkg::WHERE_W-1:0]  out_where,
  output logic [sat_pkg::KEY_W-1:0]    out_removed_key,
  output logic [sat_pkg::FILL_W-1:0]   out_fill
);

  import sat_pkg::*;

  localparam int IW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int XW  = CW + POS_W;
  localparam int WXW = IW + WHERE_W;
  localparam int FXW = CW + FILL_W;

  // Control state
  sat_state_t     state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           s1_v_r, s1_v_nxt;

  // Request and datapath registers
  sat_req_t       req_r, req_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic           dup_r, dup_nxt;
  logic [CW-1:0]  lo_r, lo_nxt;
  logic [CW-1:0]  hi_p1_r, hi_p1_nxt;
  logic [IW-1:0]  mid_r, mid_nxt;
  logic [IW-1:0]  probe_r, probe_nxt;
  logic           hit_r, hit_nxt;
  logic           gt_r, gt_nxt;
  logic [IW-1:0]  idx_r, idx_nxt;
  logic [IW-1:0]  ptr_r, ptr_nxt;
  logic [CW-1:0]  left_r, left_nxt;
  logic           ins_r, ins_nxt;
  logic           first_r, first_nxt;
  logic           s1_first_r, s1_first_nxt;
  logic [IW-1:0]  s1_waddr_r, s1_waddr_nxt;
  logic           res_ok_r, res_ok_nxt;
  logic [IW-1:0]  res_where_r, res_where_nxt;
  logic [KEY_WIDTH-1:0] res_removed_r, res_removed_nxt;

  // Output registers
  logic                 out_ok_r, out_ok_nxt;
  logic [WHERE_W-1:0]   out_where_r, out_where_nxt;
  logic [KEY_W-1:0]     out_removed_key_r, out_removed_key_nxt;
  logic [FILL_W-1:0]    out_fill_r, out_fill_nxt;

  // Memory port
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [KEY_WIDTH-1:0] ram_wdata;
  logic [IW-1:0]        ram_raddr;
  logic [KEY_WIDTH-1:0] ram_rdata;

  // Helpers
  logic [63:0]          key_ext;
  logic [KEY_WIDTH-1:0] key_m;
  logic [XW-1:0]        pos_x;
  logic [CW:0]          mid_sum;
  logic [IW-1:0]        mid_w;
  logic [CW-1:0]        cnt_m1;
  logic [IW-1:0]        ins_idx;
  logic [WXW-1:0]       where_x;
  logic [FXW-1:0]       fill_x;
  logic [63:0]          rem_x;
  logic                 in_fire;

  assign key_ext = {32'b0, in_key};
  assign key_m   = key_ext[KEY_WIDTH-1:0];
  assign pos_x   = XW'(in_position);
  assign mid_sum = (CW + 1)'(lo_r) + (CW + 1)'(hi_p1_r) - (CW + 1)'(1);
  assign mid_w   = mid_sum[IW:1];
  assign cnt_m1  = count_r - CW'(1);
  assign ins_idx = gt_r ? (probe_r + IW'(1)) : probe_r;
  assign where_x = WXW'(res_where_r);
  assign rem_x   = 64'(res_removed_r);
  assign in_fire = in_valid && in_ready;

  assign in_ready = (state_r == ST_IDLE);

  sat_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_WIDTH)
  ) u_sat_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state, datapath and memory port control
  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    s1_v_nxt        = 1'b0;
    req_nxt         = req_r;
    key_nxt         = key_r;
    dup_nxt         = dup_r;
    lo_nxt          = lo_r;
    hi_p1_nxt       = hi_p1_r;
    mid_nxt         = mid_r;
    probe_nxt       = probe_r;
    hit_nxt         = hit_r;
    gt_nxt          = gt_r;
    idx_nxt         = idx_r;
    ptr_nxt         = ptr_r;
    left_nxt        = left_r;
    ins_nxt         = ins_r;
    first_nxt       = first_r;
    s1_first_nxt    = s1_first_r;
    s1_waddr_nxt    = s1_waddr_r;
    res_ok_nxt      = res_ok_r;
    res_where_nxt   = res_where_r;
    res_removed_nxt = res_removed_r;
    out_ok_nxt          = out_ok_r;
    out_where_nxt       = out_where_r;
    out_removed_key_nxt = out_removed_key_r;
    out_fill_nxt        = out_fill_r;
    fill_x          = FXW'(count_r);
    ram_we          = 1'b0;
    ram_waddr       = s1_waddr_r;
    ram_wdata       = ram_rdata;
    ram_raddr       = mid_w;

    case (state_r)
      // Capture the transaction and start search or shift, or go straight to done on a full add or a bad position
      ST_IDLE: begin
        if (in_fire) begin
          req_nxt         = sat_req_t'(in_req_type);
          key_nxt         = key_m;
          dup_nxt         = in_allow_dup;
          lo_nxt          = '0;
          hi_p1_nxt       = count_r;
          probe_nxt       = '0;
          hit_nxt         = 1'b0;
          gt_nxt          = 1'b0;
          res_ok_nxt      = 1'b0;
          res_where_nxt   = '0;
          res_removed_nxt = '0;
          case (sat_req_t'(in_req_type))
            REQ_ADD: begin
              if (count_r == CW'(CAPACITY)) begin
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_PROBE;
              end
            end
            REQ_RM_POS: begin
              if (pos_x < XW'(count_r)) begin
                idx_nxt       = pos_x[IW-1:0];
                ptr_nxt       = pos_x[IW-1:0];
                left_nxt      = count_r - CW'(pos_x[IW-1:0]);
                ins_nxt       = 1'b0;
                first_nxt     = 1'b1;
                res_ok_nxt    = 1'b1;
                res_where_nxt = pos_x[IW-1:0];
                state_nxt     = ST_SHIFT;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            default: begin
              state_nxt = ST_PROBE;
            end
          endcase
        end
      end

      // Issue a probe read, or end the search
      ST_PROBE: begin
        if (lo_r < hi_p1_r) begin
          ram_raddr = mid_w;
          mid_nxt   = mid_w;
          state_nxt = ST_CMP;
        end else begin
          state_nxt = ST_DECIDE;
        end
      end

      // Compare the probed entry: stop on a match, else narrow the range
      ST_CMP: begin
        probe_nxt = mid_r;
        if (key_r == ram_rdata) begin
          hit_nxt   = 1'b1;
          gt_nxt    = 1'b0;
          state_nxt = ST_DECIDE;
        end else if (key_r < ram_rdata) begin
          hi_p1_nxt = CW'(mid_r);
          gt_nxt    = 1'b0;
          state_nxt = ST_PROBE;
        end else begin
          lo_nxt    = CW'(mid_r) + CW'(1);
          gt_nxt    = 1'b1;
          state_nxt = ST_PROBE;
        end
      end

      // Act on the search outcome
      ST_DECIDE: begin
        case (req_r)
          REQ_FIND: begin
            res_ok_nxt    = hit_r;
            res_where_nxt = probe_r;
            state_nxt     = ST_DONE;
          end
          REQ_ADD: begin
            if (hit_r && !dup_r) begin
              state_nxt = ST_DONE;
            end else begin
              idx_nxt       = ins_idx;
              ptr_nxt       = cnt_m1[IW-1:0];
              left_nxt      = count_r - CW'(ins_idx);
              ins_nxt       = 1'b1;
              first_nxt     = 1'b0;
              res_ok_nxt    = 1'b1;
              res_where_nxt = ins_idx;
              state_nxt     = ST_SHIFT;
            end
          end
          REQ_RM_KEY: begin
            if (hit_r) begin
              idx_nxt       = probe_r;
              ptr_nxt       = probe_r;
              left_nxt      = count_r - CW'(probe_r);
              ins_nxt       = 1'b0;
              first_nxt     = 1'b1;
              res_ok_nxt    = 1'b1;
              res_where_nxt = probe_r;
              state_nxt     = ST_SHIFT;
            end else begin
              state_nxt = ST_DONE;
            end
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end

      // Move entries one per cycle: read now, write back next cycle; on a remove the first read yields the removed key
      ST_SHIFT: begin
        if (left_r != '0) begin
          ram_raddr    = ptr_r;
          s1_v_nxt     = 1'b1;
          s1_first_nxt = first_r;
          first_nxt    = 1'b0;
          left_nxt     = left_r - CW'(1);
          if (ins_r) begin
            s1_waddr_nxt = ptr_r + IW'(1);
            ptr_nxt      = ptr_r - IW'(1);
          end else begin
            s1_waddr_nxt = ptr_r - IW'(1);
            ptr_nxt      = ptr_r + IW'(1);
          end
        end
        if (s1_v_r) begin
          if (s1_first_r) begin
            res_removed_nxt = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = s1_waddr_r;
            ram_wdata = ram_rdata;
          end
        end
        if ((left_r == '0) && !s1_v_r) begin
          state_nxt = ST_FIN;
        end
      end

      // On an add drop the new key in place; update the count either way
      ST_FIN: begin
        if (ins_r) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r;
          ram_wdata = key_r;
          count_nxt = count_r + CW'(1);
        end else begin
          count_nxt = count_r - CW'(1);
        end
        state_nxt = ST_DONE;
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_ok_nxt          = res_ok_r;
          out_where_nxt       = where_x[WHERE_W-1:0];
          out_removed_key_nxt = rem_x[KEY_W-1:0];
          out_fill_nxt        = fill_x[FILL_W-1:0];
          state_nxt           = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      s1_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      s1_v_r      <= s1_v_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r             <= req_nxt;
    key_r             <= key_nxt;
    dup_r             <= dup_nxt;
    lo_r              <= lo_nxt;
    hi_p1_r           <= hi_p1_nxt;
    mid_r             <= mid_nxt;
    probe_r           <= probe_nxt;
    hit_r             <= hit_nxt;
    gt_r              <= gt_nxt;
    idx_r             <= idx_nxt;
    ptr_r             <= ptr_nxt;
    left_r            <= left_nxt;
    ins_r             <= ins_nxt;
    first_r           <= first_nxt;
    s1_first_r        <= s1_first_nxt;
    s1_waddr_r        <= s1_waddr_nxt;
    res_ok_r          <= res_ok_nxt;
    res_where_r       <= res_where_nxt;
    res_removed_r     <= res_removed_nxt;
    out_ok_r          <= out_ok_nxt;
    out_where_r       <= out_where_nxt;
    out_removed_key_r <= out_removed_key_nxt;
    out_fill_r        <= out_fill_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_where       = out_where_r;
  assign out_removed_key = out_removed_key_r;
  assign out_fill        = out_fill_r;

endmodule

// ===== hw/rtl/sat_checker.sv =====
`include "assert_macros.svh"

module sat_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_ok,
  input logic [sat_pkg::WHERE_W-1:0] out_where,
  input logic [sat_pkg::KEY_W-1:0]   out_removed_key,
  input logic [sat_pkg::FILL_W-1:0]  out_fill
);

  // A stalled result holds its payload
  `SAT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_ok) && $stable(out_where) && $stable(out_removed_key) && $stable(out_fill), "stalled result changed")

  // One transaction in flight: input closes right after an accept
  `SAT_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "second transaction accepted while busy")

  // A failed request reports no removed key
  `SAT_ASSERT_IMP(a_fail_clean, clk, rst_n, out_valid && !out_ok, out_removed_key == '0, "failed request carries a removed key")

endmodule

bind sorted_array_table sat_checker u_sat_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_ok          (out_ok),
  .out_where       (out_where),
  .out_removed_key (out_removed_key),
  .out_fill        (out_fill)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import sat_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 400;
  localparam int LONG_HOLD = 600;
  localparam int CALM_TAIL = 150;
  localparam logic [KEY_W-1:0] KEY_MASK =
    (SAT_KEY_WIDTH >= KEY_W) ? '1 : KEY_W'((64'd1 << SAT_KEY_WIDTH) - 1);

  typedef struct {
    sat_req_t          kind;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  pos;
    logic              dup;
  } table_req_t;

  typedef struct {
    logic               ok;
    logic [WHERE_W-1:0] where;
    logic [KEY_W-1:0]   removed_key;
    logic [FILL_W-1:0]  fill;
  } table_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [REQ_W-1:0] in_req_type = '0;
  logic [KEY_W-1:0] in_key = '0;
  logic [POS_W-1:0] in_position = '0;
  logic in_allow_dup = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_ok;
  logic [WHERE_W-1:0] out_where;
  logic [KEY_W-1:0] out_removed_key;
  logic [FILL_W-1:0] out_fill;

  sorted_array_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_key(in_key),
    .in_position(in_position), .in_allow_dup(in_allow_dup),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_ok(out_ok), .out_where(out_where),
    .out_removed_key(out_removed_key), .out_fill(out_fill)
  );

  always #2 clk = ~clk;

  // Shadow copy of the table contents
  logic [KEY_W-1:0] shadow_keys [SAT_CAPACITY];
  int shadow_fill = 0;

  table_req_t request_fifo[$];
  table_resp_t pending_responses[$];
  logic [KEY_W-1:0] added_keys[$];

  logic req_taken = 1'b0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int idle_cycles = 0;
  int results_seen = 0;
  int error_count = 0;
  int kind_count [4] = '{0, 0, 0, 0};
  int ok_count = 0;
  int peak_fill = 0;
  int full_refusals = 0;
  int empty_requests = 0;

  // Binary search over the shadow table; probe is the last index looked at
  function automatic bit search_key(input logic [KEY_W-1:0] k, output int probe);
    int lo, hi, mid;
    lo = 0;
    hi = shadow_fill - 1;
    mid = 0;
    while (lo <= hi) begin
      mid = (lo + hi) >> 1;
      if (k < shadow_keys[mid]) hi = mid - 1;
      else if (k > shadow_keys[mid]) lo = mid + 1;
      else begin
        probe = mid;
        return 1'b1;
      end
    end
    probe = mid;
    return 1'b0;
  endfunction

  // Take one entry out and close the hole
  function automatic logic [KEY_W-1:0] take_entry(input int idx);
    logic [KEY_W-1:0] k;
    k = shadow_keys[idx];
    shadow_fill--;
    for (int j = idx; j < shadow_fill; j++) shadow_keys[j] = shadow_keys[j + 1];
    return k;
  endfunction

  // Apply one request to the shadow table and return the response it should give
  function automatic table_resp_t apply_table_request(input table_req_t r);
    table_resp_t res;
    int idx;
    bit hit;
    logic [KEY_W-1:0] k;
    res = '{ok: 1'b0, where: '0, removed_key: '0, fill: '0};
    k = r.key & KEY_MASK;
    idx = 0;
    case (r.kind)
      REQ_ADD: begin
        if (shadow_fill < SAT_CAPACITY) begin
          hit = search_key(k, idx);
          if (!hit || r.dup) begin
            if (shadow_fill != 0) begin
              if (k > shadow_keys[idx]) idx++;
              for (int j = shadow_fill; j > idx; j--) shadow_keys[j] = shadow_keys[j - 1];
            end else begin
              idx = 0;
            end
            shadow_keys[idx] = k;
            shadow_fill++;
            res.ok = 1'b1;
            res.where = WHERE_W'(idx);
          end
        end
      end
      REQ_FIND: begin
        res.ok = search_key(k, idx);
        res.where = WHERE_W'(idx);
      end
      REQ_RM_KEY: begin
        if (search_key(k, idx)) begin
          res.removed_key = take_entry(idx);
          res.ok = 1'b1;
          res.where = WHERE_W'(idx);
        end
      end
      default: begin
        if (int'(r.pos) < shadow_fill) begin
          res.removed_key = take_entry(int'(r.pos));
          res.ok = 1'b1;
          res.where = r.pos;
        end
      end
    endcase
    res.fill = FILL_W'(shadow_fill);
    return res;
  endfunction

  // Stimulus helpers
  task automatic queue_request(input sat_req_t kind, input logic [KEY_W-1:0] key,
                               input logic [POS_W-1:0] pos, input logic dup);
    table_req_t r;
    r = '{kind: kind, key: key, pos: pos, dup: dup};
    request_fifo.push_back(r);
    if (kind == REQ_ADD) begin
      added_keys.push_back(key);
      if (added_keys.size() > 400) void'(added_keys.pop_front());
    end
  endtask

  // Mostly reuse keys already offered so finds and removes hit
  function automatic logic [KEY_W-1:0] pick_key(input int fresh_pct);
    logic [KEY_W-1:0] k;
    if (added_keys.size() != 0 && $urandom_range(99) >= fresh_pct) begin
      k = added_keys[$urandom_range(added_keys.size() - 1)];
    end else begin
      case ($urandom_range(7))
        0: k = '0;
        1: k = '1;
        2: k = KEY_W'($urandom_range(63));
        default: k = $urandom;
      endcase
    end
    return k;
  endfunction

  task automatic queue_phase(input int count, input int add_pct, input int find_pct,
                             input int rmkey_pct);
    int roll;
    logic [POS_W-1:0] pos;
    logic dup;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      pos = ($urandom_range(1) == 0) ? POS_W'($urandom_range(31)) : POS_W'($urandom_range(255));
      dup = ($urandom_range(99) < 60);
      if (roll < add_pct) queue_request(REQ_ADD, pick_key(45), pos, dup);
      else if (roll < add_pct + find_pct) queue_request(REQ_FIND, pick_key(30), pos, dup);
      else if (roll < add_pct + find_pct + rmkey_pct)
        queue_request(REQ_RM_KEY, pick_key(20), pos, dup);
      else queue_request(REQ_RM_POS, $urandom, pos, dup);
    end
  endtask

  // Driver: present the next transaction at the falling edge
  always @(negedge clk) begin
    logic next_valid;
    table_req_t cur;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid && !req_taken;
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (request_fifo.size() != 0) begin
          cur = request_fifo.pop_front();
          in_req_type <= cur.kind;
          in_key <= cur.key;
          in_position <= cur.pos;
          in_allow_dup <= cur.dup;
          next_valid = 1'b1;
          if (request_fifo.size() >= CALM_TAIL && $urandom_range(5) == 0)
            send_gap = $urandom_range(1, 11);
        end
      end
      in_valid <= next_valid;
    end
  end

  // Receiver: random stall bursts, one long hold to back up the input
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 150) begin
      hold_done = 1;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (request_fifo.size() >= CALM_TAIL && $urandom_range(6) == 0) begin
      stall_left = $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    table_req_t r;
    table_resp_t exp_resp;
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        r = '{kind: sat_req_t'(in_req_type), key: in_key, pos: in_position, dup: in_allow_dup};
        kind_count[in_req_type]++;
        if (shadow_fill == 0) empty_requests++;
        if (r.kind == REQ_ADD && shadow_fill == SAT_CAPACITY) full_refusals++;
        pending_responses.push_back(apply_table_request(r));
        if (shadow_fill > peak_fill) peak_fill = shadow_fill;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_ok === 1'b1) ok_count++;
        if (pending_responses.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR %0t: unexpected result ok=%b where=%0d removed=%h fill=%0d",
                     $realtime, out_ok, out_where, out_removed_key, out_fill);
        end else begin
          exp_resp = pending_responses.pop_front();
          if (out_ok !== exp_resp.ok || out_where !== exp_resp.where ||
              out_removed_key !== exp_resp.removed_key || out_fill !== exp_resp.fill) begin
            error_count++;
            if (error_count <= 10)
              $display("ERROR %0t: result %0d expected ok=%b where=%0d removed=%h fill=%0d, got ok=%b where=%0d removed=%h fill=%0d",
                       $realtime, results_seen, exp_resp.ok, exp_resp.where,
                       exp_resp.removed_key, exp_resp.fill, out_ok, out_where,
                       out_removed_key, out_fill);
          end
        end
      end
      // Watchdog on transaction activity
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    // Empty table cases
    queue_request(REQ_FIND, '0, '0, 1'b0);
    queue_request(REQ_RM_KEY, 32'd5, '0, 1'b1);
    queue_request(REQ_RM_POS, '0, '0, 1'b0);
    // Plain, refused duplicate and accepted duplicate adds, key extremes
    queue_request(REQ_ADD, 32'd100, '0, 1'b0);
    queue_request(REQ_ADD, 32'd100, '0, 1'b0);
    queue_request(REQ_ADD, 32'd100, 8'hFF, 1'b1);
    queue_request(REQ_ADD, '0, '0, 1'b0);
    queue_request(REQ_ADD, '1, '0, 1'b0);
    queue_request(REQ_ADD, 32'h8000_0000, '0, 1'b1);
    // Hits and misses
    queue_request(REQ_FIND, 32'd100, '0, 1'b0);
    queue_request(REQ_FIND, 32'd50, '0, 1'b0);
    queue_request(REQ_FIND, '1, 8'hAA, 1'b1);
    queue_request(REQ_FIND, 32'hFFFF_FFFE, 8'h55, 1'b0);
    // Removes: out of range, last entry, out of range again, by key, absent key, first entry
    queue_request(REQ_RM_POS, '0, 8'hFF, 1'b0);
    queue_request(REQ_RM_POS, '0, 8'd4, 1'b0);
    queue_request(REQ_RM_POS, '0, 8'd4, 1'b1);
    queue_request(REQ_RM_KEY, 32'd100, '0, 1'b0);
    queue_request(REQ_RM_KEY, 32'd7, '0, 1'b0);
    queue_request(REQ_RM_POS, '0, '0, 1'b0);
    queue_request(REQ_ADD, 32'h5555_5555, '0, 1'b1);
    queue_request(REQ_ADD, 32'hAAAA_AAAA, 8'h80, 1'b0);
    queue_request(REQ_FIND, 32'hAAAA_AAAA, 8'hFF, 1'b1);
    queue_request(REQ_RM_KEY, 32'd100, '0, 1'b1);
    queue_request(REQ_RM_KEY, 32'h5555_5555, 8'h0F, 1'b0);

    // Random part: fill to capacity, churn, drain, refill, churn
    queue_phase(500, 88, 4, 4);
    queue_phase(250, 30, 20, 25);
    queue_phase(450, 8, 12, 40);
    queue_phase(300, 80, 10, 5);
    queue_phase(200, 30, 20, 25);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (request_fifo.size() != 0 || in_valid || pending_responses.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d add, %0d find, %0d remove by key, %0d remove at position, %0d ok",
             results_seen, kind_count[REQ_ADD], kind_count[REQ_FIND],
             kind_count[REQ_RM_KEY], kind_count[REQ_RM_POS], ok_count);
    $display("Peak fill %0d of %0d, %0d adds refused on a full table, %0d requests on an empty table",
             peak_fill, SAT_CAPACITY, full_refusals, empty_requests);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/sat_pkg.sv
hw/rtl/sat_ram.sv
hw/rtl/sorted_array_table.sv
hw/rtl/sat_checker.sv
sim/testbench.sv
